>>> hw/rtl/maob_pkg.sv
// ----------------------------------------------------------------------------
// maob_pkg
// Shared types, constants and helper functions for the masked one-hot
// arithmetic-to-Boolean converter.
// ----------------------------------------------------------------------------
package maob_pkg;

    // Width of the one-hot share registers and of the position index.
    localparam int LOG_REG          = 5;
    localparam int REG_W            = 32;
    localparam int COEFF_W          = 6;
    localparam int POS_W            = 6;
    localparam int CARRY_WIDTH_DEF  = 1;

    localparam logic [COEFF_W-1:0] COEFF_BITS_RST = 6'd13;

    // Masks that select the one-hot positions whose index has bit j set.
    localparam logic [REG_W-1:0] POS_BIT_MASK [LOG_REG] = '{
        32'hAAAA_AAAA,
        32'hCCCC_CCCC,
        32'hF0F0_F0F0,
        32'hFF00_FF00,
        32'hFFFF_0000
    };

    // One input item: a digit of each arithmetic share and two remask words.
    typedef struct packed {
        logic [LOG_REG-1:0] share0_digit;
        logic [LOG_REG-1:0] share1_digit;
        logic [REG_W-1:0]   rand_first;
        logic [REG_W-1:0]   rand_second;
    } t_in_item;

    // One result item: the Boolean share bits of a digit and its place.
    typedef struct packed {
        logic [LOG_REG-1:0] bool0_digit;
        logic [LOG_REG-1:0] bool1_digit;
        logic [LOG_REG-1:0] digit_offset;
        logic               last_digit;
    } t_out_item;

    // Running state carried from one digit to the next.
    typedef struct packed {
        logic [REG_W-1:0] onehot_share0;
        logic [REG_W-1:0] onehot_share1;
        logic [POS_W-1:0] bit_position;
    } t_share_state;

    localparam t_share_state SHARE_STATE_RST = '{
        onehot_share0: 32'h0000_0001,
        onehot_share1: 32'h0000_0000,
        bit_position:  6'd0
    };

    // Rotate left; a rotate by zero returns the word unchanged.
    function automatic logic [REG_W-1:0] rotl32(input logic [REG_W-1:0] v,
                                                input logic [LOG_REG-1:0] n);
        logic [2*REG_W-1:0] w;
        w = {v, v} << n;
        return w[2*REG_W-1:REG_W];
    endfunction

    // Boolean bits of the one-hot position, low 'width' bits only.
    function automatic logic [LOG_REG-1:0] extract_bits(input logic [REG_W-1:0] v,
                                                        input logic [2:0] width);
        logic [LOG_REG-1:0] b;
        b = '0;
        for (int j = 0; j < LOG_REG; j++) begin
            if (3'(j) < width) begin
                b[j] = ^(v & POS_BIT_MASK[j]);
            end
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/maob_if.sv
// ----------------------------------------------------------------------------
// maob_in_if / maob_out_if
// Valid/ready channels carrying input digits and Boolean result digits.
// ----------------------------------------------------------------------------
interface maob_in_if
    import maob_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface maob_out_if
    import maob_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/maob_digit.sv
// ----------------------------------------------------------------------------
// maob_digit
// Datapath for one digit: masked rotations, Boolean extraction and the carry
// collapse that prepares the share registers for the next digit.
// ----------------------------------------------------------------------------
module maob_digit
    import maob_pkg::*;
#(
    parameter int CARRY_WIDTH = CARRY_WIDTH_DEF
) (
    input  t_in_item           i_item,
    input  t_share_state       i_state,
    input  logic [COEFF_W-1:0] i_coeff_bits,
    output t_out_item          o_result,
    output t_share_state       o_state
);

    localparam int DIGIT_BITS = LOG_REG - CARRY_WIDTH;
    localparam int SPAN       = 1 << DIGIT_BITS;
    localparam logic [LOG_REG-1:0] DIGIT_MASK = LOG_REG'((1 << DIGIT_BITS) - 1);
    localparam logic [REG_W-1:0]   CARRY_MASK = REG_W'((1 << (1 << CARRY_WIDTH)) - 1);

    // Fold a share register so that only the carry out of the digit remains,
    // as a one-hot value in the low bits.
    function automatic logic [REG_W-1:0] collapse_carry(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] t;
        logic [REG_W-1:0] keep;
        t    = v;
        keep = '0;
        for (int i = 0; i < DIGIT_BITS; i++) begin
            t = t ^ (t >> (1 << i));
        end
        for (int k = 0; k < REG_W; k += SPAN) begin
            keep[k] = 1'b1;
        end
        t = t & keep;
        for (int j = 0; j < 6; j++) begin
            if (((SPAN - 1) << j) < REG_W) begin
                t = t ^ (t >> ((SPAN - 1) << j));
            end
        end
        return t & CARRY_MASK;
    endfunction

    logic                 last;
    logic [COEFF_W:0]     pos_ext;
    logic [COEFF_W:0]     coeff_ext;
    logic [COEFF_W:0]     diff;
    logic [2:0]           width;
    logic [LOG_REG-1:0]   d0;
    logic [LOG_REG-1:0]   d1;
    logic [REG_W-1:0]     s0_a;
    logic [REG_W-1:0]     s1_a;
    logic [REG_W-1:0]     s0_b;
    logic [REG_W-1:0]     s1_b;

    // Digit kind and the number of valid Boolean bits in it.
    always_comb begin
        pos_ext   = {1'b0, i_state.bit_position};
        coeff_ext = {1'b0, i_coeff_bits};
        diff      = coeff_ext - pos_ext;
        last      = (pos_ext + 7'd5) >= coeff_ext;
        if (!last) begin
            width = 3'(DIGIT_BITS);
        end else if (coeff_ext > pos_ext) begin
            width = (diff > 7'd5) ? 3'd5 : diff[2:0];
        end else begin
            width = 3'd0;
        end
    end

    // Non-final digits only use the low digit bits of each share.
    assign d0 = last ? i_item.share0_digit : (i_item.share0_digit & DIGIT_MASK);
    assign d1 = last ? i_item.share1_digit : (i_item.share1_digit & DIGIT_MASK);

    // Rotate by each arithmetic share, remasking after each rotation.
    assign s0_a = rotl32(i_state.onehot_share0, d0) ^ i_item.rand_first;
    assign s1_a = rotl32(i_state.onehot_share1, d0) ^ i_item.rand_first;
    assign s0_b = rotl32(s0_a, d1) ^ i_item.rand_second;
    assign s1_b = rotl32(s1_a, d1) ^ i_item.rand_second;

    // Result fields for this digit.
    always_comb begin
        o_result.bool0_digit  = extract_bits(s0_b, width);
        o_result.bool1_digit  = extract_bits(s1_b, width);
        o_result.digit_offset = i_state.bit_position[LOG_REG-1:0];
        o_result.last_digit   = last;
    end

    // State for the following digit: fresh after the last one, else the carry.
    always_comb begin
        if (last) begin
            o_state = SHARE_STATE_RST;
        end else begin
            o_state.onehot_share0 = collapse_carry(s0_b);
            o_state.onehot_share1 = collapse_carry(s1_b);
            o_state.bit_position  = i_state.bit_position + POS_W'(DIGIT_BITS);
        end
    end

endmodule

>>> hw/rtl/masked_onehot_arith_to_bool_core.sv
// ----------------------------------------------------------------------------
// masked_onehot_arith_to_bool_core
// Two-share arithmetic-to-Boolean masked conversion, one digit per transfer.
// ----------------------------------------------------------------------------
// Usage:
// - i_in_ch carries one digit of each arithmetic share plus two fresh random
//   words per transfer; o_out_ch returns one result per input transfer with
//   the two Boolean share digits, the bit offset and a last-digit flag.
// - i_cfg_we / i_cfg_wdata set the coefficient width; write it only while
//   the block holds no unfinished digit.
// - A digit passes the input register and then the result register; the
//   result register offers its result on o_out_ch.
// - Throughput: one digit per cycle while o_out_ch.ready is high. The share
//   state loop is a single pass of rotate, remask and carry collapse between
//   the input and result registers, so digits follow each other with no gap.
// - Reset clears the share registers to their initial one-hot value, the
//   bit position to zero, the width to 13 and both valid flags.
// - When the receiver stalls, the result register holds; one more item
//   waits in the input register and then i_in_ch.ready goes low.
// ----------------------------------------------------------------------------
module masked_onehot_arith_to_bool_core
    import maob_pkg::*;
#(
    parameter int CARRY_WIDTH = CARRY_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COEFF_W-1:0] i_cfg_wdata,
    maob_in_if.sink            i_in_ch,
    maob_out_if.source         o_out_ch
);

    logic               r_in_vld;
    t_in_item           r_in;
    logic               r_out_vld;
    t_out_item          r_out;
    t_share_state       r_state;
    logic [COEFF_W-1:0] r_coeff_bits;

    t_out_item          n_out;
    t_share_state       n_state;
    logic               advance;

    // A digit moves on when the result register is free or being emptied.
    assign advance         = r_in_vld && (!r_out_vld || o_out_ch.ready);
    assign i_in_ch.ready   = !r_in_vld || advance;
    assign o_out_ch.valid  = r_out_vld;
    assign o_out_ch.data   = r_out;

    // Per-digit datapath.
    maob_digit #(
        .CARRY_WIDTH (CARRY_WIDTH)
    ) u_digit (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_coeff_bits (r_coeff_bits),
        .o_result     (n_out),
        .o_state      (n_state)
    );

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_state      <= SHARE_STATE_RST;
            r_coeff_bits <= COEFF_BITS_RST;
        end else begin
            if (i_in_ch.ready) begin
                r_in_vld <= i_in_ch.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_coeff_bits <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in <= i_in_ch.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/maob_checker.sv
// ----------------------------------------------------------------------------
// maob_checker
// Port-level checks for the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module maob_checker
    import maob_pkg::*;
#(
    parameter int CARRY_WIDTH = CARRY_WIDTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    localparam int DIGIT_BITS = LOG_REG - CARRY_WIDTH;

    // A stalled result stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed or dropped while stalled");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Every input transfer is followed by a valid result on the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("no result two cycles after an input transfer");

    // A non-final digit carries only the low digit bits of each share.
    a_digit_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.last_digit) |->
        (((i_out_data.bool0_digit >> DIGIT_BITS) == '0) &&
         ((i_out_data.bool1_digit >> DIGIT_BITS) == '0)))
        else $error("Boolean bits above the digit width on a non-final digit");

endmodule

bind masked_onehot_arith_to_bool_core maob_checker #(
    .CARRY_WIDTH (CARRY_WIDTH)
) u_maob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data)
);

>>> tb/tb_masked_onehot_arith_to_bool_core.sv
// ----------------------------------------------------------------------------
// tb_masked_onehot_arith_to_bool_core
// Self-checking bench for the masked arithmetic-to-Boolean digit converter.
// A short table of directed digits and width writes is walked first. Long
// random phases follow, each under a new coefficient width. Every accepted
// digit is run through a local model of the share registers. Each returned
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_masked_onehot_arith_to_bool_core
    import maob_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RST_CYCLES   = 12;
    localparam int RANDOM_ITEMS = 535;
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;

    // Digit geometry: a non-final digit leaves room for the carry bits.
    localparam int CARRY_W = CARRY_WIDTH_DEF;
    localparam int DIGIT_W = LOG_REG - CARRY_W;
    localparam int SPAN    = 1 << DIGIT_W;
    localparam logic [LOG_REG-1:0] DIGIT_MASK = LOG_REG'((1 << DIGIT_W) - 1);

    // One row of the directed table: either a width write or a digit.
    typedef struct packed {
        bit                 is_write;
        logic [COEFF_W-1:0] width_val;
        t_in_item           digit;
        bit                 has_want;
        t_out_item          want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COEFF_W-1:0] i_cfg_wdata;

    maob_in_if  in_ch ();
    maob_out_if out_ch ();

    masked_onehot_arith_to_bool_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Local copy of the share registers, the digit position and the width.
    logic [REG_W-1:0]   share0_reg = 32'h0000_0001;
    logic [REG_W-1:0]   share1_reg = '0;
    logic [POS_W-1:0]   pos_cnt    = '0;
    logic [COEFF_W-1:0] width_cfg  = COEFF_BITS_RST;

    t_out_item pending_digits[$];
    t_out_item want_digit;
    t_dir_row  dir_rows[$];
    int        mismatches = 0;

    // Clock generation.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Left rotation of a share register; a zero amount leaves it alone.
    function automatic logic [REG_W-1:0] rot_left(input logic [REG_W-1:0] v,
                                                  input logic [LOG_REG-1:0] n);
        if (n == 0) begin
            return v;
        end
        return (v << n) | (v >> (32 - n));
    endfunction

    // Parity of the positions whose index has bit j set, for the low w bits.
    function automatic logic [LOG_REG-1:0] digit_bits(input logic [REG_W-1:0] r,
                                                      input int w);
        logic [LOG_REG-1:0] b;
        logic [REG_W-1:0]   sel;
        b = '0;
        for (int j = 0; j < LOG_REG; j++) begin
            for (int k = 0; k < REG_W; k++) begin
                sel[k] = k[j];
            end
            if (j < w) begin
                b[j] = ^(r & sel);
            end
        end
        return b;
    endfunction

    // Reduce a share register to its carry, kept one-hot in the lowest bits.
    function automatic logic [REG_W-1:0] fold_carry(input logic [REG_W-1:0] r);
        logic [REG_W-1:0] keep;
        for (int i = 0; i < DIGIT_W; i++) begin
            r = r ^ (r >> (1 << i));
        end
        keep = 32'd1;
        for (int i = SPAN; i < REG_W; i = i << 1) begin
            keep = keep + (keep << i);
        end
        r = r & keep;
        for (int i = SPAN - 1; i < REG_W; i = i << 1) begin
            r = r ^ (r >> i);
        end
        return r & ((32'd1 << (1 << CARRY_W)) - 1);
    endfunction

    // Convert one digit: rotate and remask both shares, read the Boolean
    // bits and then fold the registers ready for the next digit.
    function automatic t_out_item convert_digit(input t_in_item it);
        t_out_item          res;
        logic [LOG_REG-1:0] d0;
        logic [LOG_REG-1:0] d1;
        bit                 fin;
        int                 w;
        d0  = it.share0_digit;
        d1  = it.share1_digit;
        fin = (int'(pos_cnt) + LOG_REG) >= int'(width_cfg);
        if (fin) begin
            w = (width_cfg > pos_cnt) ? int'(width_cfg) - int'(pos_cnt) : 0;
            if (w > LOG_REG) begin
                w = LOG_REG;
            end
        end else begin
            w  = DIGIT_W;
            d0 = d0 & DIGIT_MASK;
            d1 = d1 & DIGIT_MASK;
        end
        share0_reg = rot_left(share0_reg, d0) ^ it.rand_first;
        share1_reg = rot_left(share1_reg, d0) ^ it.rand_first;
        share0_reg = rot_left(share0_reg, d1) ^ it.rand_second;
        share1_reg = rot_left(share1_reg, d1) ^ it.rand_second;
        res.bool0_digit  = digit_bits(share0_reg, w);
        res.bool1_digit  = digit_bits(share1_reg, w);
        res.digit_offset = pos_cnt[LOG_REG-1:0];
        res.last_digit   = fin;
        if (fin) begin
            share0_reg = 32'h0000_0001;
            share1_reg = '0;
            pos_cnt    = '0;
        end else begin
            share0_reg = fold_carry(share0_reg);
            share1_reg = fold_carry(share1_reg);
            pos_cnt    = pos_cnt + POS_W'(DIGIT_W);
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_dir_row width_row(input logic [COEFF_W-1:0] v);
        t_dir_row row;
        row           = '0;
        row.is_write  = 1'b1;
        row.width_val = v;
        return row;
    endfunction

    function automatic t_dir_row digit_row(input logic [4:0] d0, input logic [4:0] d1,
                                           input logic [31:0] r0, input logic [31:0] r1);
        t_dir_row row;
        row                    = '0;
        row.digit.share0_digit = d0;
        row.digit.share1_digit = d1;
        row.digit.rand_first   = r0;
        row.digit.rand_second  = r1;
        return row;
    endfunction

    function automatic t_dir_row known_row(input logic [4:0] d0, input logic [4:0] d1,
                                           input logic [4:0] b0, input logic [4:0] b1,
                                           input logic [4:0] off, input logic fin);
        t_dir_row row;
        row                   = digit_row(d0, d1, '0, '0);
        row.has_want          = 1'b1;
        row.want.bool0_digit  = b0;
        row.want.bool1_digit  = b1;
        row.want.digit_offset = off;
        row.want.last_digit   = fin;
        return row;
    endfunction

    // Hold off the sender until every predicted result has been returned.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_digits.size() != 0);
    endtask

    // Write the coefficient width once the converter has gone quiet.
    task automatic set_width(input logic [COEFF_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        width_cfg = v;
    endtask

    // Present one digit after an optional gap and log its expected result
    // once the transfer has taken place.
    task automatic send_digit(input t_in_item it, input bit has_want,
                              input t_out_item want, input int gap);
        t_out_item pred;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = convert_digit(it);
        pending_digits.push_back(has_want ? want : pred);
    endtask

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result monitor: every transfer on the output is matched in order.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time,
                         out_ch.data);
                mismatches++;
            end else begin
                want_digit = pending_digits.pop_front();
                check_field("bool0_digit", want_digit.bool0_digit,
                            out_ch.data.bool0_digit);
                check_field("bool1_digit", want_digit.bool1_digit,
                            out_ch.data.bool1_digit);
                check_field("digit_offset", want_digit.digit_offset,
                            out_ch.data.digit_offset);
                check_field("last_digit", {4'd0, want_digit.last_digit},
                            {4'd0, out_ch.data.last_digit});
            end
        end
    end

    // Receiver: bursts of ready broken by stalls, with long quiet stretches.
    initial begin
        int run;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if ($urandom_range(0, 9) < 7) begin
                out_ch.ready <= 1'b0;
                if ($urandom_range(0, 9) < 8) begin
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Run limit.
    initial begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

    // Stimulus.
    initial begin
        t_in_item           it;
        logic [COEFF_W-1:0] width_plan[8];
        int                 items_left;
        int                 phase;
        int                 span_len;
        bit                 steady;
        int                 waited;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        width_plan  = '{6'd63, 6'd0, 6'd32, 6'd6, 6'd5, 6'd1, 6'd13, 6'd7};

        // Directed table. Typed results: a zero digit from reset, masking of
        // the top digit bit, a carry into the next digit, a zero-width digit
        // and a one-bit coefficient.
        dir_rows.push_back(known_row(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        dir_rows.push_back(digit_row(5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_rows.push_back(digit_row(5'd31, 5'd1, 32'h1234_5678, 32'h9ABC_DEF0));
        dir_rows.push_back(known_row(5'd16, 5'd16, 5'd0, 5'd0, 5'd0, 1'b0));
        dir_rows.push_back(known_row(5'd1, 5'd0, 5'd1, 5'd0, 5'd4, 1'b0));
        dir_rows.push_back(known_row(5'd0, 5'd0, 5'd0, 5'd0, 5'd8, 1'b1));
        dir_rows.push_back(digit_row(5'd7, 5'd9, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        dir_rows.push_back(digit_row(5'd0, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000));
        dir_rows.push_back(digit_row(5'd31, 5'd0, 32'h0000_0000, 32'hFFFF_FFFF));
        dir_rows.push_back(width_row(6'd0));
        dir_rows.push_back(known_row(5'd31, 5'd31, 5'd0, 5'd0, 5'd0, 1'b1));
        dir_rows.push_back(width_row(6'd1));
        dir_rows.push_back(known_row(5'd1, 5'd0, 5'd1, 5'd0, 5'd0, 1'b1));
        dir_rows.push_back(width_row(6'd5));
        dir_rows.push_back(digit_row(5'd31, 5'd31, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
        dir_rows.push_back(width_row(6'd6));
        dir_rows.push_back(digit_row(5'd15, 5'd15, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        dir_rows.push_back(digit_row(5'd31, 5'd31, 32'h8000_0001, 32'h7FFF_FFFE));
        dir_rows.push_back(width_row(6'd13));
        dir_rows.push_back(known_row(5'd15, 5'd15, 5'd14, 5'd0, 5'd0, 1'b0));
        dir_rows.push_back(known_row(5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 1'b0));
        dir_rows.push_back(known_row(5'd0, 5'd0, 5'd0, 5'd0, 5'd8, 1'b1));

        // Reset.
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                set_width(dir_rows[i].width_val);
            end else begin
                send_digit(dir_rows[i].digit, dir_rows[i].has_want, dir_rows[i].want,
                           pick_idle());
            end
        end

        // Random phases, each under its own width; a phase may well end in
        // the middle of a coefficient.
        items_left = RANDOM_ITEMS;
        phase      = 0;
        while (items_left > 0) begin
            set_width(phase < 8 ? width_plan[phase] : COEFF_W'($urandom_range(0, 63)));
            span_len = $urandom_range(20, 60);
            steady   = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < span_len && items_left > 0; n++) begin
                it.share0_digit = LOG_REG'($urandom_range(0, 31));
                it.share1_digit = LOG_REG'($urandom_range(0, 31));
                it.rand_first   = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
                it.rand_second  = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
                if ($urandom_range(0, 49) == 0) begin
                    drain_results();
                end
                send_digit(it, 1'b0, '0, steady ? 0 : pick_idle());
                items_left--;
            end
            phase++;
        end

        // Let the last results come back, then close the run.
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_digits.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_digits.size() != 0) begin
            $display("%0t: %0d results missing, expected %h first, got none", $time,
                     pending_digits.size(), pending_digits[0]);
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
